### sv/vcg_pkg.sv
// shared types, widths, register indexes and reset values of the velocity command guard
package vcg_pkg;

	localparam int SPEED_BITS = 16;
	localparam int CFG_BITS = 15;
	localparam int AGE_BITS = 8;
	localparam int TIMEOUT_BITS = 8;
	localparam int CFG_INDEX_BITS = 3;
	// compare width: room for the 15-bit limits, their negation and one difference
	localparam int CALC_BITS = ((SPEED_BITS > CFG_BITS + 1) ? SPEED_BITS : CFG_BITS + 1) + 2;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LINEAR = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ANGULAR = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_LINEAR = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_ANGULAR = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND_LINEAR = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND_ANGULAR = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 3'd6;

	localparam logic [CFG_BITS-1:0] RST_MAX_LINEAR = 15'd2048;
	localparam logic [CFG_BITS-1:0] RST_MAX_ANGULAR = 15'd4096;
	localparam logic [CFG_BITS-1:0] RST_STEP_LINEAR = 15'd82;
	localparam logic [CFG_BITS-1:0] RST_STEP_ANGULAR = 15'd410;
	localparam logic [CFG_BITS-1:0] RST_DEADBAND_LINEAR = 15'd82;
	localparam logic [CFG_BITS-1:0] RST_DEADBAND_ANGULAR = 15'd205;
	localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT_TICKS = 8'd6;

	typedef struct packed {
		logic operation;
		logic signed [SPEED_BITS-1:0] linear_cmd;
		logic signed [SPEED_BITS-1:0] angular_cmd;
	} in_beat_t;

	typedef struct packed {
		logic signed [SPEED_BITS-1:0] linear_out;
		logic signed [SPEED_BITS-1:0] angular_out;
		logic timed_out;
	} out_beat_t;

endpackage

### sv/velocity_command_guard.sv
// velocity command guard: timeout, magnitude clamp, slew limit and deadband on two channels
// a tick beat's result is registered in the output register, or in the skid while the output beat is held
// throughput: one beat per cycle while the skid is empty, commands and ticks alike; one
//   compare-and-select pass between the state registers and the result register sets that figure
// a two-entry result buffer (output register plus skid) keeps input open while a result waits
// reset: arst_n low clears the state, loads the register defaults and empties the buffer
module velocity_command_guard (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [vcg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [vcg_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  vcg_pkg::in_beat_t                     in_beat,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output vcg_pkg::out_beat_t                    out_beat
);

	localparam int SB = vcg_pkg::SPEED_BITS;
	localparam int CB = vcg_pkg::CALC_BITS;
	localparam int FB = vcg_pkg::CFG_BITS;

	// widen a speed value, sign extended, to the compare width
	function automatic logic signed [CB-1:0] wide_speed(input logic [SB-1:0] v);
		wide_speed = $signed({{(CB-SB){v[SB-1]}}, v});
	endfunction

	// widen an unsigned limit register to the compare width
	function automatic logic signed [CB-1:0] wide_cfg(input logic [FB-1:0] v);
		wide_cfg = $signed({{(CB-FB){1'b0}}, v});
	endfunction

	// clamp to plus or minus the limit
	function automatic logic signed [CB-1:0] clamp_mag(
		input logic signed [CB-1:0] v,
		input logic signed [CB-1:0] lim
	);
		logic signed [CB-1:0] res;
		res = v;
		if (v > lim) begin
			res = lim;
		end else if (v < -lim) begin
			res = -lim;
		end
		clamp_mag = res;
	endfunction

	// step toward the target by at most one step, then zero small magnitudes
	function automatic logic signed [CB-1:0] slew_db(
		input logic signed [CB-1:0] tgt,
		input logic signed [CB-1:0] last,
		input logic signed [CB-1:0] step,
		input logic signed [CB-1:0] db
	);
		logic signed [CB-1:0] diff;
		logic signed [CB-1:0] res;
		logic signed [CB-1:0] mag;
		diff = tgt - last;
		res = tgt;
		if (diff > step) begin
			res = last + step;
		end else if (diff < -step) begin
			res = last - step;
		end
		mag = (res < 0) ? -res : res;
		if (mag < db) begin
			res = '0;
		end
		slew_db = res;
	endfunction

	// configuration registers
	logic [FB-1:0] max_lin_q, max_ang_q, step_lin_q, step_ang_q, db_lin_q, db_ang_q;
	logic [vcg_pkg::TIMEOUT_BITS-1:0] timeout_q;

	// guard state
	logic signed [SB-1:0] target_lin_q, target_ang_q;
	logic signed [SB-1:0] last_lin_q, last_ang_q;
	logic have_cmd_q;
	logic first_q;
	logic [vcg_pkg::AGE_BITS-1:0] age_q;

	// result buffer
	logic out_valid_q;
	vcg_pkg::out_beat_t out_beat_q;
	logic skid_valid_q;
	vcg_pkg::out_beat_t skid_beat_q;

	logic in_acc;
	logic is_cmd;
	logic is_tick;
	logic [vcg_pkg::AGE_BITS-1:0] age_next;
	logic tick_timeout;
	logic res_valid;
	vcg_pkg::out_beat_t res_beat;
	logic signed [CB-1:0] clamp_lin, clamp_ang;
	logic signed [CB-1:0] guard_lin, guard_ang;
	logic out_free;

	// a new beat is taken whenever the skid stage is empty
	assign in_stall = skid_valid_q;
	assign in_acc = in_valid && !skid_valid_q;
	assign is_cmd = in_acc && (in_beat.operation == vcg_pkg::OP_COMMAND);
	assign is_tick = in_acc && (in_beat.operation == vcg_pkg::OP_TICK) && have_cmd_q;

	// age saturates at its all-ones value, then is compared against the timeout
	assign age_next = (age_q != '1) ? age_q + 1'b1 : age_q;
	assign tick_timeout = age_next > timeout_q;

	always_comb begin
		clamp_lin = clamp_mag(wide_speed(target_lin_q), wide_cfg(max_lin_q));
		clamp_ang = clamp_mag(wide_speed(target_ang_q), wide_cfg(max_ang_q));
		if (first_q) begin
			// first output passes the clamped target straight through
			guard_lin = clamp_lin;
			guard_ang = clamp_ang;
		end else begin
			guard_lin = slew_db(clamp_lin, wide_speed(last_lin_q), wide_cfg(step_lin_q),
				wide_cfg(db_lin_q));
			guard_ang = slew_db(clamp_ang, wide_speed(last_ang_q), wide_cfg(step_ang_q),
				wide_cfg(db_ang_q));
		end
	end

	always_comb begin
		res_valid = is_tick;
		if (tick_timeout) begin
			res_beat.linear_out = '0;
			res_beat.angular_out = '0;
			res_beat.timed_out = 1'b1;
		end else begin
			res_beat.linear_out = guard_lin[SB-1:0];
			res_beat.angular_out = guard_ang[SB-1:0];
			res_beat.timed_out = 1'b0;
		end
	end

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q <= vcg_pkg::RST_MAX_LINEAR;
			max_ang_q <= vcg_pkg::RST_MAX_ANGULAR;
			step_lin_q <= vcg_pkg::RST_STEP_LINEAR;
			step_ang_q <= vcg_pkg::RST_STEP_ANGULAR;
			db_lin_q <= vcg_pkg::RST_DEADBAND_LINEAR;
			db_ang_q <= vcg_pkg::RST_DEADBAND_ANGULAR;
			timeout_q <= vcg_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				vcg_pkg::REG_MAX_LINEAR: max_lin_q <= cfg_data;
				vcg_pkg::REG_MAX_ANGULAR: max_ang_q <= cfg_data;
				vcg_pkg::REG_STEP_LINEAR: step_lin_q <= cfg_data;
				vcg_pkg::REG_STEP_ANGULAR: step_ang_q <= cfg_data;
				vcg_pkg::REG_DEADBAND_LINEAR: db_lin_q <= cfg_data;
				vcg_pkg::REG_DEADBAND_ANGULAR: db_ang_q <= cfg_data;
				vcg_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg_data[vcg_pkg::TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// guard state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_lin_q <= '0;
			target_ang_q <= '0;
			last_lin_q <= '0;
			last_ang_q <= '0;
			have_cmd_q <= 1'b0;
			first_q <= 1'b1;
			age_q <= '0;
		end else if (is_cmd) begin
			target_lin_q <= in_beat.linear_cmd;
			target_ang_q <= in_beat.angular_cmd;
			have_cmd_q <= 1'b1;
			age_q <= '0;
		end else if (is_tick) begin
			age_q <= age_next;
			// a timed-out tick leaves the last values and the first flag alone
			if (!tick_timeout) begin
				last_lin_q <= guard_lin[SB-1:0];
				last_ang_q <= guard_ang[SB-1:0];
				first_q <= 1'b0;
			end
		end
	end

	// output register with skid: the skid only fills while the output beat is held
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_beat_q <= skid_valid_q ? skid_beat_q : res_beat;
		end else if (res_valid) begin
			skid_beat_q <= res_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat = out_beat_q;

endmodule

### sv/vcg_checker.sv
// port-level checks of the velocity command guard and their bind
module vcg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input vcg_pkg::in_beat_t                   in_beat,
	input logic                                out_valid,
	input logic                                out_stall,
	input vcg_pkg::out_beat_t                  out_beat
);

	// a held result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a timeout beat carries zero speeds
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.timed_out |->
			(out_beat.linear_out == '0) && (out_beat.angular_out == '0))
		else $error("timeout beat with nonzero speed");

	// input stalls only while a result beat is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// a command beat into an empty output side produces no result
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_beat.operation == vcg_pkg::OP_COMMAND) && !out_valid
			|=> !out_valid)
		else $error("command beat produced a result");

endmodule

bind velocity_command_guard vcg_checker u_vcg_checker (.*);

### test/velocity_command_guard_test.sv
// self-checking testbench for the velocity command guard, with its scoreboard class
class guard_scoreboard;
	logic [vcg_pkg::CFG_BITS-1:0] lim_lin, lim_ang, slew_lin, slew_ang, dead_lin, dead_ang;
	logic [vcg_pkg::TIMEOUT_BITS-1:0] age_limit;
	logic signed [vcg_pkg::SPEED_BITS-1:0] goal_lin, goal_ang, prev_lin, prev_ang;
	bit armed;
	bit fresh;
	int age;
	vcg_pkg::out_beat_t guarded_q[$];
	int fail_count;

	function new();
		lim_lin = vcg_pkg::RST_MAX_LINEAR;
		lim_ang = vcg_pkg::RST_MAX_ANGULAR;
		slew_lin = vcg_pkg::RST_STEP_LINEAR;
		slew_ang = vcg_pkg::RST_STEP_ANGULAR;
		dead_lin = vcg_pkg::RST_DEADBAND_LINEAR;
		dead_ang = vcg_pkg::RST_DEADBAND_ANGULAR;
		age_limit = vcg_pkg::RST_TIMEOUT_TICKS;
		goal_lin = '0;
		goal_ang = '0;
		prev_lin = '0;
		prev_ang = '0;
		armed = 1'b0;
		fresh = 1'b1;
		age = 0;
		fail_count = 0;
	endfunction

	function void write_reg(logic [vcg_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [vcg_pkg::CFG_BITS-1:0] val);
		unique case (idx)
			vcg_pkg::REG_MAX_LINEAR: lim_lin = val;
			vcg_pkg::REG_MAX_ANGULAR: lim_ang = val;
			vcg_pkg::REG_STEP_LINEAR: slew_lin = val;
			vcg_pkg::REG_STEP_ANGULAR: slew_ang = val;
			vcg_pkg::REG_DEADBAND_LINEAR: dead_lin = val;
			vcg_pkg::REG_DEADBAND_ANGULAR: dead_ang = val;
			vcg_pkg::REG_TIMEOUT_TICKS: age_limit = val[vcg_pkg::TIMEOUT_BITS-1:0];
			default: ;
		endcase
	endfunction

	function int clamp_speed(int v, int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function int slew_speed(int goal, int last, int step, int dead);
		int d;
		int v;
		d = goal - last;
		v = goal;
		if (d > step)
			v = last + step;
		else if (d < -step)
			v = last - step;
		if ((v < 0 ? -v : v) < dead)
			v = 0;
		return v;
	endfunction

	function void note_input(vcg_pkg::in_beat_t b);
		int lo;
		int ao;
		vcg_pkg::out_beat_t r;
		if (b.operation == vcg_pkg::OP_COMMAND) begin
			goal_lin = b.linear_cmd;
			goal_ang = b.angular_cmd;
			armed = 1'b1;
			age = 0;
			return;
		end
		if (!armed)
			return;
		if (age < 255)
			age++;
		if (age > int'(age_limit)) begin
			r.linear_out = '0;
			r.angular_out = '0;
			r.timed_out = 1'b1;
			guarded_q.push_back(r);
			return;
		end
		lo = clamp_speed(int'(goal_lin), int'(lim_lin));
		ao = clamp_speed(int'(goal_ang), int'(lim_ang));
		if (fresh) begin
			fresh = 1'b0;
		end else begin
			lo = slew_speed(lo, int'(prev_lin), int'(slew_lin), int'(dead_lin));
			ao = slew_speed(ao, int'(prev_ang), int'(slew_ang), int'(dead_ang));
		end
		prev_lin = lo[vcg_pkg::SPEED_BITS-1:0];
		prev_ang = ao[vcg_pkg::SPEED_BITS-1:0];
		r.linear_out = lo[vcg_pkg::SPEED_BITS-1:0];
		r.angular_out = ao[vcg_pkg::SPEED_BITS-1:0];
		r.timed_out = 1'b0;
		guarded_q.push_back(r);
	endfunction

	function void check_result(vcg_pkg::out_beat_t got);
		vcg_pkg::out_beat_t want;
		if (guarded_q.size() == 0) begin
			$error("unexpected result beat: linear_out %0d angular_out %0d timed_out %0b",
				got.linear_out, got.angular_out, got.timed_out);
			fail_count++;
			return;
		end
		want = guarded_q.pop_front();
		if (got.linear_out !== want.linear_out) begin
			$error("linear_out expected %0d actual %0d", want.linear_out, got.linear_out);
			fail_count++;
		end
		if (got.angular_out !== want.angular_out) begin
			$error("angular_out expected %0d actual %0d", want.angular_out, got.angular_out);
			fail_count++;
		end
		if (got.timed_out !== want.timed_out) begin
			$error("timed_out expected %0b actual %0b", want.timed_out, got.timed_out);
			fail_count++;
		end
	endfunction

	function int outstanding();
		return guarded_q.size();
	endfunction
endclass

module velocity_command_guard_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [vcg_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [vcg_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	vcg_pkg::in_beat_t in_beat = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vcg_pkg::out_beat_t out_beat;

	guard_scoreboard sb;

	// idle rates in percent of cycles, changed between phases
	int send_idle_pct = 0;
	int stall_pct = 0;
	// long receiver hold-off: requested by the stimulus, counted down by the receiver
	bit hold_req = 1'b0;
	int hold_left = 0;

	velocity_command_guard u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: check every accepted result beat, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_beat);
		if (hold_req) begin
			hold_left = 300;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// offer one beat, with a random gap first, and return at the edge that takes it;
	// valid stays high so a following beat goes out back to back
	task automatic push_beat(input vcg_pkg::in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(b);
	endtask

	// stop offering, wait for every expected result, then let the pipeline settle
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [vcg_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [vcg_pkg::CFG_BITS-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// write all seven registers back to back, enable lowered only after the last one
	task automatic apply_settings(input logic [vcg_pkg::CFG_BITS-1:0] ml,
			input logic [vcg_pkg::CFG_BITS-1:0] ma,
			input logic [vcg_pkg::CFG_BITS-1:0] sl, input logic [vcg_pkg::CFG_BITS-1:0] sa,
			input logic [vcg_pkg::CFG_BITS-1:0] dl, input logic [vcg_pkg::CFG_BITS-1:0] da,
			input logic [vcg_pkg::CFG_BITS-1:0] to);
		set_reg(vcg_pkg::REG_MAX_LINEAR, ml);
		set_reg(vcg_pkg::REG_MAX_ANGULAR, ma);
		set_reg(vcg_pkg::REG_STEP_LINEAR, sl);
		set_reg(vcg_pkg::REG_STEP_ANGULAR, sa);
		set_reg(vcg_pkg::REG_DEADBAND_LINEAR, dl);
		set_reg(vcg_pkg::REG_DEADBAND_ANGULAR, da);
		set_reg(vcg_pkg::REG_TIMEOUT_TICKS, to);
		cfg_wen <= 1'b0;
	endtask

	// register value: zero, all ones, or something up to span
	function automatic logic [vcg_pkg::CFG_BITS-1:0] pick_cfg(input int unsigned span);
		unique case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return vcg_pkg::CFG_BITS'($urandom_range(span));
		endcase
	endfunction

	function automatic logic [vcg_pkg::CFG_BITS-1:0] pick_timeout();
		unique case ($urandom_range(7))
			0: return vcg_pkg::CFG_BITS'(254);
			1: return vcg_pkg::CFG_BITS'($urandom_range(254));
			default: return vcg_pkg::CFG_BITS'($urandom_range(12));
		endcase
	endfunction

	// speed value: full range, the range ends and zero, or small around the deadbands
	function automatic logic signed [vcg_pkg::SPEED_BITS-1:0] pick_speed();
		int s;
		unique case ($urandom_range(5))
			0: return {1'b0, {(vcg_pkg::SPEED_BITS-1){1'b1}}};
			1: return {1'b1, {(vcg_pkg::SPEED_BITS-1){1'b0}}};
			2: return '0;
			3: begin
				s = $urandom_range(1200);
				s = s - 600;
				return s[vcg_pkg::SPEED_BITS-1:0];
			end
			default: return vcg_pkg::SPEED_BITS'($urandom);
		endcase
	endfunction

	function automatic vcg_pkg::in_beat_t command_beat(
			input logic signed [vcg_pkg::SPEED_BITS-1:0] lin,
			input logic signed [vcg_pkg::SPEED_BITS-1:0] ang);
		vcg_pkg::in_beat_t b;
		b.operation = vcg_pkg::OP_COMMAND;
		b.linear_cmd = lin;
		b.angular_cmd = ang;
		return b;
	endfunction

	// tick beats carry random speed fields, which the block must ignore
	function automatic vcg_pkg::in_beat_t tick_beat();
		vcg_pkg::in_beat_t b;
		b.operation = vcg_pkg::OP_TICK;
		b.linear_cmd = vcg_pkg::SPEED_BITS'($urandom);
		b.angular_cmd = vcg_pkg::SPEED_BITS'($urandom);
		return b;
	endfunction

	// mostly a command followed by a run of ticks; now and then a command that is
	// replaced at once, or a run long enough to hit the timeout
	task automatic run_segment(input int n_items);
		int count;
		int ticks;
		count = 0;
		while (count < n_items) begin
			push_beat(command_beat(pick_speed(), pick_speed()));
			count++;
			if ($urandom_range(9) == 0)
				continue;
			ticks = $urandom_range(1, 10);
			if ($urandom_range(7) == 0 && sb.age_limit < 40)
				ticks = sb.age_limit + 3;
			repeat (ticks) begin
				push_beat(tick_beat());
				count++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles a little, receiver a lot
		send_idle_pct = 16;
		stall_pct = 50;

		// directed part on the reset settings
		push_beat(tick_beat());                      // tick before any command: no result
		push_beat(command_beat(16'sh7FFF, 16'sh8000));
		push_beat(tick_beat());                      // first output passes the clamped value
		push_beat(tick_beat());
		push_beat(command_beat(16'sh8000, 16'sh7FFF));
		push_beat(tick_beat());                      // full reversal, slew limited
		push_beat(tick_beat());
		push_beat(command_beat(16'sd40, -16'sd100)); // small targets, walk down
		push_beat(tick_beat());
		repeat (6) push_beat(tick_beat());           // age runs past the timeout
		push_beat(tick_beat());
		push_beat(command_beat(-16'sd1, 16'sd1));    // fresh command clears the age
		push_beat(tick_beat());
		push_beat(command_beat(16'sd0, 16'sd0));
		push_beat(tick_beat());
		push_beat(tick_beat());
		drain_and_settle();

		// upper extremes: largest clamp and step limits, no deadband, longest timeout
		apply_settings('1, '1, '1, '1, '0, '0, vcg_pkg::CFG_BITS'(254));
		run_segment(80);
		drain_and_settle();

		// zero limit, zero step and huge deadband on linear, timeout of one
		apply_settings('0, '1, '0, '1, '1, '0, vcg_pkg::CFG_BITS'(1));
		run_segment(80);
		drain_and_settle();

		// other way round: sender idles a lot, receiver a little
		send_idle_pct = 50;
		stall_pct = 16;

		// zero timeout: every tick after a command is forced to zero
		apply_settings(pick_cfg(12000), pick_cfg(12000), pick_cfg(2000), pick_cfg(2000),
			pick_cfg(600), pick_cfg(600), '0);
		run_segment(80);
		drain_and_settle();

		apply_settings(pick_cfg(12000), pick_cfg(12000), pick_cfg(2000), pick_cfg(2000),
			pick_cfg(600), pick_cfg(600), pick_timeout());
		run_segment(80);
		drain_and_settle();

		// no idling; the receiver holds off for a long stretch first, so the block fills
		send_idle_pct = 0;
		stall_pct = 0;
		apply_settings(pick_cfg(12000), pick_cfg(12000), pick_cfg(2000), pick_cfg(2000),
			pick_cfg(600), pick_cfg(600), pick_timeout());
		hold_req = 1'b1;
		run_segment(80);
		drain_and_settle();

		apply_settings(pick_cfg(12000), pick_cfg(12000), pick_cfg(2000), pick_cfg(2000),
			pick_cfg(600), pick_cfg(600), pick_timeout());
		run_segment(80);
		drain_and_settle();

		if (sb.fail_count == 0 && sb.outstanding() == 0)
			$display("velocity_command_guard_test OK");
		else
			$display("velocity_command_guard_test NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("velocity_command_guard_test NOT OK");
		$finish;
	end

endmodule

### files.f
sv/vcg_pkg.sv
sv/velocity_command_guard.sv
sv/vcg_checker.sv
test/velocity_command_guard_test.sv
